>>> rtl/sha256_sha224_hash_core_macros.svh
// assertion macros for the sha-256/224 hash core checker
`ifndef SHA256_SHA224_HASH_CORE_MACROS_SVH
`define SHA256_SHA224_HASH_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define SHA2_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha2 check failed");

// next-cycle implication, masked during reset
`define SHA2_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha2 check failed");

// next-cycle implication that also holds across reset
`define SHA2_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sha2 check failed");

`endif

>>> rtl/sha2_pkg.sv
// shared types, constants and tables of the sha-256/224 hash core
`default_nettype none
package sha2_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] work_type;

   localparam int unsigned CountWidth = 61;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_256 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] IV_224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [8:0] {
      ST_INIT     = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_PAD      = 9'b000000100,
      ST_LOAD     = 9'b000001000,
      ST_ROUND    = 9'b000010000,
      ST_UPDATE   = 9'b000100000,
      ST_OUT_RD   = 9'b001000000,
      ST_OUT_LD   = 9'b010000000,
      ST_OUT_WAIT = 9'b100000000
   } state_type;

   // control from the sequencer to the round datapath
   typedef struct packed {
      logic       shift_en;
      logic [7:0] shift_byte;
      logic       load_en;
      logic [2:0] load_idx;
      word_type   load_word;
      logic       round_en;
      word_type   round_k;
   } round_ctrl_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

>>> rtl/sha2_if.sv
// handshake channels of the sha-256/224 hash core
`default_nettype none
interface sha2_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha2_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   logic        length_overflow;
   modport source (output valid, digest_word, word_index, last_word, length_overflow,
                   input ready);
   modport sink (input valid, digest_word, word_index, last_word, length_overflow,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_sha224_hash_core.sv
// sha-256 / sha-224 hash core, byte-wide message input, word-wide digest output
//
//   channel   dir   payload                                            moves
//   req_chan  in    data_byte, byte_present, end_of_message            one byte or finish
//   rsp_chan  out   digest_word, word_index, last_word, length_overflow one digest word
//   csr       in    digest_mode                                        mode write
//
// a byte that does not fill a block is only shifted into the buffer; a full block then runs
// the chain reads, 64 rounds in the shared round unit and the read-add-write steps
// finishing pads one byte a cycle, compresses once or twice (not after a length overflow),
// then reads, loads and offers each digest word until rsp_chan takes it; the iv is then reloaded
// reset and a mode write reload the iv into the chain ram before any input is taken
// input is taken only while no block or digest is in flight
`default_nettype none
module sha256_sha224_hash_core
   import sha2_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sha2_req_if.sink   req_chan,
   sha2_rsp_if.source rsp_chan,
   input  wire logic csr_write_en,
   input  wire logic csr_write_data
);

   // sequencer state
   state_type              state_ff, state_in;
   logic [5:0]             step_ff, step_in;
   logic [CountWidth-1:0]  count_ff, count_in;    // message length in bytes
   logic [5:0]             pos_ff, pos_in;        // byte position in block
   logic                   ovf_ff, ovf_in;
   logic                   mode_ff, mode_in;
   logic                   fin_pend_ff, fin_pend_in;  // finish waits for a compress
   logic                   pad_act_ff, pad_act_in;
   logic                   pad_first_ff, pad_first_in;
   logic                   final_ff, final_in;    // current block carries the length

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_word_ff, rsp_word_in;
   logic [2:0]             rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // chain ram
   logic                   ram_wr_en;
   logic [2:0]             ram_wr_addr;
   word_type               ram_wr_data;
   logic [2:0]             ram_rd_addr;
   word_type               ram_rd_data;

   round_ctrl_type         ctrl;
   work_type               work;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   take_byte;
   logic                   ovf_hit;
   logic [63:0]            bit_len;
   logic [7:0]             len_byte;
   logic [2:0]             prev_idx;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // a byte is dropped once the bit count would pass 2^64 - 1
   assign ovf_hit   = req_chan.byte_present && !ovf_ff && (&count_ff);
   assign take_byte = req_chan.byte_present && !ovf_ff && !(&count_ff);

   assign bit_len  = {count_ff, 3'b000};
   assign len_byte = 8'(bit_len >> {3'd7 - pos_ff[2:0], 3'b000});
   assign prev_idx = step_ff[2:0] - 3'd1;

   sha2_ram #(.Width(32), .Depth(8)) u_chain_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sha2_round u_round (
      .clock (clock),
      .ctrl  (ctrl),
      .work  (work)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      mode_in      = mode_ff;
      fin_pend_in  = fin_pend_ff;
      pad_act_in   = pad_act_ff;
      pad_first_in = pad_first_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = prev_idx;
      ram_wr_data  = ram_rd_data + work[prev_idx];
      ram_rd_addr  = step_ff[2:0];

      ctrl            = '0;
      ctrl.load_idx   = prev_idx;
      ctrl.load_word  = ram_rd_data;
      ctrl.round_k    = ROUND_K[step_ff];

      unique case (state_ff)
         ST_INIT: begin
            // write the iv of the selected mode, one word a cycle
            ram_wr_en    = 1'b1;
            ram_wr_addr  = step_ff[2:0];
            ram_wr_data  = mode_ff ? IV_224[step_ff[2:0]] : IV_256[step_ff[2:0]];
            count_in     = '0;
            pos_in       = '0;
            ovf_in       = 1'b0;
            fin_pend_in  = 1'b0;
            pad_act_in   = 1'b0;
            pad_first_in = 1'b0;
            final_in     = 1'b0;
            step_in      = step_ff + 6'd1;
            if (step_ff[2:0] == 3'd7) begin
               state_in = ST_IDLE;
               step_in  = '0;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (ovf_hit) begin
                  ovf_in = 1'b1;
               end
               if (take_byte) begin
                  ctrl.shift_en   = 1'b1;
                  ctrl.shift_byte = req_chan.data_byte;
                  count_in        = count_ff + CountWidth'(1);
                  pos_in          = pos_ff + 6'd1;
               end
               step_in = '0;
               if (take_byte && (&pos_ff)) begin
                  state_in    = ST_LOAD;
                  fin_pend_in = req_chan.end_of_message;
               end else if (req_chan.end_of_message) begin
                  if (ovf_ff || ovf_hit) begin
                     state_in = ST_OUT_RD;
                  end else begin
                     state_in     = ST_PAD;
                     pad_act_in   = 1'b1;
                     pad_first_in = 1'b1;
                  end
               end
            end
         end
         ST_PAD: begin
            // marker byte, zeros, then the big-endian bit length in the last block
            ctrl.shift_en = 1'b1;
            if (pad_first_ff) begin
               ctrl.shift_byte = PAD_MARK;
               final_in        = !(pos_ff[5:3] == 3'b111);
            end else if (final_ff && (pos_ff[5:3] == 3'b111)) begin
               ctrl.shift_byte = len_byte;
            end else begin
               ctrl.shift_byte = 8'h00;
            end
            pad_first_in = 1'b0;
            pos_in       = pos_ff + 6'd1;
            if (&pos_ff) begin
               state_in = ST_LOAD;
               step_in  = '0;
            end
         end
         ST_LOAD: begin
            // chain words into the working registers, each loaded the cycle after its registered ram read
            ctrl.load_en = (step_ff != 6'd0);
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'd8) begin
               state_in = ST_ROUND;
               step_in  = '0;
            end
         end
         ST_ROUND: begin
            ctrl.round_en = 1'b1;
            step_in       = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_UPDATE;
               step_in  = '0;
            end
         end
         ST_UPDATE: begin
            // read chain word i, write it back plus working word in the next cycle
            ram_wr_en = (step_ff != 6'd0);
            step_in   = step_ff + 6'd1;
            if (step_ff == 6'd8) begin
               step_in = '0;
               if (pad_act_ff) begin
                  if (final_ff) begin
                     state_in = ST_OUT_RD;
                  end else begin
                     state_in = ST_PAD;
                     final_in = 1'b1;
                  end
               end else if (fin_pend_ff) begin
                  state_in     = ST_PAD;
                  pad_act_in   = 1'b1;
                  pad_first_in = 1'b1;
                  fin_pend_in  = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = ovf_ff ? '0 : ram_rd_data;
            rsp_idx_in   = step_ff[2:0];
            rsp_last_in  = (step_ff[2:0] == (mode_ff ? 3'd6 : 3'd7));
            rsp_ovf_in   = ovf_ff;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_INIT;
                  step_in  = '0;
               end else begin
                  state_in = ST_OUT_RD;
                  step_in  = step_ff + 6'd1;
               end
            end
         end
         default: begin
            state_in = ST_INIT;
            step_in  = '0;
         end
      endcase

      // mode write aborts the message and reloads the iv
      if (csr_write_en) begin
         mode_in      = csr_write_data;
         state_in     = ST_INIT;
         step_in      = '0;
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         step_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         fin_pend_ff  <= 1'b0;
         pad_act_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         mode_ff      <= mode_in;
         fin_pend_ff  <= fin_pend_in;
         pad_act_ff   <= pad_act_in;
         pad_first_ff <= pad_first_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.digest_word     = rsp_word_ff;
   assign rsp_chan.word_index      = rsp_idx_ff;
   assign rsp_chan.last_word       = rsp_last_ff;
   assign rsp_chan.length_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

>>> rtl/sha2_ram.sv
// generic single-write, single-read ram with registered read
`default_nettype none
module sha2_ram #(
   parameter int Width = 32,
   parameter int Depth = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/sha2_round.sv
// block buffer, message schedule and working words with one round per cycle
`default_nettype none
module sha2_round
   import sha2_pkg::*;
(
   input  wire logic           clock,
   input  wire round_ctrl_type ctrl,
   output work_type            work
);

   word_type sched_ff [16];
   word_type sched_new;
   work_type work_ff;
   work_type work_in;
   word_type t1;
   word_type t2;

   // next schedule word from the 16-word window
   always_comb begin
      sched_new = (rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10))
                + sched_ff[9]
                + (rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3))
                + sched_ff[0];
   end

   always_comb begin
      t1 = work_ff[7]
         + (rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25))
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + ctrl.round_k + sched_ff[0];
      t2 = (rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22))
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
            (work_ff[1] & work_ff[2]));
      work_in = work_ff;
      if (ctrl.round_en) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end else if (ctrl.load_en) begin
         work_in[ctrl.load_idx] = ctrl.load_word;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (ctrl.shift_en) begin
         // whole buffer moves up one byte
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_ff[15] <= {sched_ff[15][23:0], ctrl.shift_byte};
      end else if (ctrl.round_en) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= sched_new;
      end
   end

   assign work = work_ff;

endmodule
`default_nettype wire

>>> rtl/sha2_check.sv
// port-level checks of the sha-256/224 hash core, bound to the top level
`default_nettype none
`include "sha256_sha224_hash_core_macros.svh"
module sha2_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_index,
   input wire logic       rsp_last,
   input wire logic       rsp_ovf,
   input wire logic [31:0] rsp_word,
   input wire logic       csr_write_en
);

   `SHA2_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid && !req_ready)
   `SHA2_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready)
   `SHA2_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last, !rsp_valid)
   `SHA2_ASSERT_NOW(a_ovf_zero, rsp_valid && rsp_ovf, rsp_word == 32'd0)
   `SHA2_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready && !csr_write_en,
                     rsp_valid && $stable(rsp_index))

endmodule

bind sha256_sha224_hash_core sha2_check u_sha2_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_index    (rsp_chan.word_index),
   .rsp_last     (rsp_chan.last_word),
   .rsp_ovf      (rsp_chan.length_overflow),
   .rsp_word     (rsp_chan.digest_word),
   .csr_write_en (csr_write_en)
);
`default_nettype wire
